// ===== rtl/core/qkd_pkg.sv =====
// Shared types, constants and the quadrature step table for the knob decoder.
package qkd_pkg;

	localparam int LOCKOUT_BITS_DEF = 16;
	localparam int LOCK_W           = 16;
	localparam int POS_W            = 32;
	localparam int PRESS_W          = 16;

	localparam logic [POS_W-1:0]  MIN_POS_RST  = 32'h8000_0000;
	localparam logic [POS_W-1:0]  MAX_POS_RST  = 32'h7FFF_FFFF;
	localparam logic [LOCK_W-1:0] ROT_LOCK_RST = 16'd1;
	localparam logic [LOCK_W-1:0] BTN_LOCK_RST = 16'd50;

	typedef enum logic [1:0] {
		REG_MIN_POS  = 2'd0,
		REG_MAX_POS  = 2'd1,
		REG_ROT_LOCK = 2'd2,
		REG_BTN_LOCK = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// indexed by {old phase, new phase}
	localparam dir_t STEP_TABLE [16] = '{
		DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE,
		DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
		DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
		DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE
	};

	// per-request strobe to the decode units
	typedef struct packed {
		logic fire;   // request in the input stage is consumed this cycle
		logic prime;  // first request after reset
	} qkd_ctl_t;

	typedef struct packed {
		logic moved;
		dir_t dir;
	} rot_res_t;

	typedef struct packed {
		logic                 changed;
		logic                 pressed;
		logic [PRESS_W-1:0]   total;
	} btn_res_t;

endpackage

// ===== rtl/core/qkd_rotation.sv =====
// Rotation path: lockout counter, transition decode and clamped position count.
module qkd_rotation #(
	parameter int LOCKOUT_BITS = qkd_pkg::LOCKOUT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qkd_pkg::qkd_ctl_t            ctl,
	input  logic [1:0]                   phase,
	input  logic [qkd_pkg::POS_W-1:0]    min_pos,
	input  logic [qkd_pkg::POS_W-1:0]    max_pos,
	input  logic [qkd_pkg::LOCK_W-1:0]   lockout,
	output qkd_pkg::rot_res_t            res,
	output logic [qkd_pkg::POS_W-1:0]    position
);
	import qkd_pkg::*;

	localparam int CW = (LOCKOUT_BITS > LOCK_W) ? LOCKOUT_BITS : LOCK_W;

	logic [1:0]              acc_phase_q;
	logic [POS_W-1:0]        pos_q;
	logic [LOCKOUT_BITS-1:0] elapsed_q;

	logic [LOCKOUT_BITS-1:0] el_bump;
	logic                    take;
	dir_t                    step;
	logic signed [POS_W:0]   step_v;
	logic signed [POS_W:0]   sum;
	logic signed [POS_W:0]   lo;
	logic signed [POS_W:0]   hi;
	logic [POS_W-1:0]        pos_new;

	always_comb begin
		el_bump = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		take    = (phase != acc_phase_q) && (CW'(el_bump) >= CW'(lockout));
		step    = STEP_TABLE[{acc_phase_q, phase}];
		case (step)
			DIR_CW:  step_v = (POS_W+1)'(1);
			DIR_CCW: step_v = '1;
			default: step_v = '0;
		endcase
		sum = $signed({pos_q[POS_W-1], pos_q}) + step_v;
		lo  = $signed({min_pos[POS_W-1], min_pos});
		hi  = $signed({max_pos[POS_W-1], max_pos});
		if (sum < lo) begin
			pos_new = min_pos;
		end else if (sum > hi) begin
			pos_new = max_pos;
		end else begin
			pos_new = sum[POS_W-1:0];
		end
		if (!take || step == DIR_NONE) begin
			pos_new = pos_q;
		end
		res.moved = !ctl.prime && take && (pos_new != pos_q);
		res.dir   = res.moved ? step : DIR_NONE;
		position  = pos_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_phase_q <= '0;
			pos_q       <= '0;
			elapsed_q   <= '1;
		end else if (ctl.fire) begin
			if (ctl.prime) begin
				acc_phase_q <= phase;
				elapsed_q   <= el_bump;
			end else if (take) begin
				acc_phase_q <= phase;
				pos_q       <= pos_new;
				elapsed_q   <= '0;
			end else begin
				elapsed_q   <= el_bump;
			end
		end
	end

endmodule

// ===== rtl/core/qkd_button.sv =====
// Button path: lockout counter, debounced level and press counter.
module qkd_button #(
	parameter int LOCKOUT_BITS = qkd_pkg::LOCKOUT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qkd_pkg::qkd_ctl_t            ctl,
	input  logic                         level,
	input  logic [qkd_pkg::LOCK_W-1:0]   lockout,
	output qkd_pkg::btn_res_t            res
);
	import qkd_pkg::*;

	localparam int CW = (LOCKOUT_BITS > LOCK_W) ? LOCKOUT_BITS : LOCK_W;

	logic                    deb_q;
	logic [PRESS_W-1:0]      press_q;
	logic [LOCKOUT_BITS-1:0] elapsed_q;

	logic [LOCKOUT_BITS-1:0] el_bump;
	logic                    pressed;
	logic                    take;
	logic [PRESS_W-1:0]      press_new;

	always_comb begin
		pressed   = !level;
		el_bump   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		take      = (pressed != deb_q) && (CW'(el_bump) >= CW'(lockout));
		press_new = (take && pressed) ? press_q + 1'b1 : press_q;
		res.changed = !ctl.prime && take;
		res.pressed = take ? pressed : deb_q;
		res.total   = press_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q     <= 1'b0;
			press_q   <= '0;
			elapsed_q <= '1;
		end else if (ctl.fire) begin
			if (ctl.prime) begin
				deb_q     <= pressed;
				elapsed_q <= el_bump;
			end else if (take) begin
				deb_q     <= pressed;
				press_q   <= press_new;
				elapsed_q <= '0;
			end else begin
				elapsed_q <= el_bump;
			end
		end
	end

endmodule

// ===== rtl/core/quadrature_knob_decoder.sv =====
// Top level of the quadrature knob decoder: input stage, config, decode units, result register.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[7:0]  one pin sample per tick
//  m_*      out  m_tvalid/m_tready   m_tdata[55:0] + m_tuser[1:0]  event result
//  cfg_*    in   cfg_we              cfg_index[1:0], cfg_data[31:0]
//
// One request per cycle sustained while no stalled result blocks the input
// stage (see below). An accepted request is held in the input register; the
// decode units then update their state and load the result register, which drives m_tvalid.
// Requests that cause no event (including the priming sample) leave no result.
// Reset clears the valid flags and decode state and loads the config defaults; no clearing pass.
// A stalled result blocks the input stage only if the next request has an event.
module quadrature_knob_decoder #(
	parameter int LOCKOUT_BITS = qkd_pkg::LOCKOUT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] phase_pair, [2] button_level, [7:3] zero
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [55:0] m_tdata,   // [1:0] step_direction, [33:2] position_out,
	                               // [34] press_state, [50:35] press_total, [55:51] zero
	output logic [1:0]  m_tuser,   // [0] rotation_event, [1] button_event
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import qkd_pkg::*;

	// configuration registers
	logic [POS_W-1:0]  min_pos_q;
	logic [POS_W-1:0]  max_pos_q;
	logic [LOCK_W-1:0] rot_lock_q;
	logic [LOCK_W-1:0] btn_lock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q  <= MIN_POS_RST;
			max_pos_q  <= MAX_POS_RST;
			rot_lock_q <= ROT_LOCK_RST;
			btn_lock_q <= BTN_LOCK_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_POS:  min_pos_q  <= cfg_data;
				REG_MAX_POS:  max_pos_q  <= cfg_data;
				REG_ROT_LOCK: rot_lock_q <= cfg_data[LOCK_W-1:0];
				REG_BTN_LOCK: btn_lock_q <= cfg_data[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic [1:0] phase_s1;
	logic       level_s1;
	logic       primed_q;

	// result register
	logic               out_valid_q;
	logic               rot_ev_q;
	logic               btn_ev_q;
	dir_t               dir_q;
	logic [POS_W-1:0]   pos_q;
	logic               pressed_q;
	logic [PRESS_W-1:0] total_q;

	qkd_ctl_t           ctl;
	rot_res_t           rot_res;
	btn_res_t           btn_res;
	logic [POS_W-1:0]   position;
	logic               has_result;
	logic               advance;

	// prime flag is known at the input stage; the event flags come from the units
	always_comb begin
		has_result = rot_res.moved || btn_res.changed;
		advance    = valid_s1 && (!has_result || !out_valid_q || m_tready);
		ctl.fire   = advance;
		ctl.prime  = !primed_q;
		s_tready   = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			phase_s1 <= s_tdata[1:0];
			level_s1 <= s_tdata[2];
		end
	end

	qkd_rotation #(
		.LOCKOUT_BITS(LOCKOUT_BITS)
	) u_rotation (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.phase    (phase_s1),
		.min_pos  (min_pos_q),
		.max_pos  (max_pos_q),
		.lockout  (rot_lock_q),
		.res      (rot_res),
		.position (position)
	);

	qkd_button #(
		.LOCKOUT_BITS(LOCKOUT_BITS)
	) u_button (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.level   (level_s1),
		.lockout (btn_lock_q),
		.res     (btn_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			rot_ev_q  <= rot_res.moved;
			btn_ev_q  <= btn_res.changed;
			dir_q     <= rot_res.dir;
			pos_q     <= position;
			pressed_q <= btn_res.pressed;
			total_q   <= btn_res.total;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, total_q, pressed_q, pos_q, dir_q};
	assign m_tuser  = {btn_ev_q, rot_ev_q};

endmodule

// ===== bench/tb_quadrature_knob_decoder.sv =====
// Self-checking testbench for the quadrature knob decoder.
`timescale 1ns / 1ps

module tb_quadrature_knob_decoder;
	import qkd_pkg::*;

	// Lockout age counters saturate at the default LOCKOUT_BITS width.
	localparam int unsigned AGE_MAX  = (1 << LOCKOUT_BITS_DEF) - 1;
	// Settle margin after the last result.
	localparam int          DRAIN_CY = 8;
	// Length of the forced receiver hold-off in the pressure phase.
	localparam int          HOLD_CY  = 300;

	// One expected event result, in the order the block reports it.
	typedef struct packed {
		logic               rot_ev;
		dir_t               dir;
		logic signed [31:0] pos;
		logic               btn_ev;
		logic               pressed;
		logic [15:0]        presses;
	} knob_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        m_tvalid;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	quadrature_knob_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [1:0] phase_pair, [2] button_level
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),   // [1:0] dir, [33:2] position, [34] pressed, [50:35] presses
		.m_tuser   (m_tuser),   // [0] rotation_event, [1] button_event
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus and scoreboard storage.
	logic [7:0]   samples_to_send[$];  // pin samples not yet offered
	knob_event_t  knob_events_due[$];  // predicted events, oldest first

	// Shadow of the decoder state and its registers.
	logic signed [31:0] min_pos, max_pos;
	logic [15:0]        rot_lock, btn_lock;
	logic [1:0]         acc_phase;
	bit                 primed;
	logic signed [31:0] knob_pos;
	bit                 deb_pressed;
	logic [15:0]        press_cnt;
	int unsigned        rot_age, btn_age;

	// Run bookkeeping.
	int mismatches = 0;
	int samples_taken = 0;
	int events_checked = 0;
	int rot_events = 0;
	int btn_events = 0;

	// Generator state: where the simulated knob sits and the button level.
	logic [1:0]  cur_ph = 2'd0;
	logic        cur_lvl = 1'b1;
	bit          spin_ccw = 0;
	int unsigned btn_left = 0;

	// Pacing controls used by the sequencer and the two bus processes.
	bit          tight_send = 0;   // sender offers back to back
	int unsigned hold_asks = 0;    // bumped to request one long receiver hold
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	bit          calm_tx = 0;
	bit          calm_rx = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Position of a phase pair along the clockwise Gray cycle 00-01-11-10.
	function automatic int gray_ord(logic [1:0] p);
		case (p)
			2'b00: return 0;
			2'b01: return 1;
			2'b11: return 2;
			default: return 3;
		endcase
	endfunction

	function automatic logic [1:0] phase_at(int ord);
		case (ord & 3)
			0: return 2'b00;
			1: return 2'b01;
			2: return 2'b11;
			default: return 2'b10;
		endcase
	endfunction

	// Mostly short gaps, a few long ones; none at all in a calm stretch.
	function automatic int unsigned draw_gap(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void reset_model();
		min_pos     = MIN_POS_RST;
		max_pos     = MAX_POS_RST;
		rot_lock    = ROT_LOCK_RST;
		btn_lock    = BTN_LOCK_RST;
		acc_phase   = '0;
		primed      = 0;
		knob_pos    = '0;
		deb_pressed = 0;
		press_cnt   = '0;
		rot_age     = AGE_MAX;
		btn_age     = AGE_MAX;
	endfunction

	// Advance the shadow state by one accepted pin sample and queue the event it causes.
	function automatic void decode_sample(logic [1:0] ph, logic lvl);
		knob_event_t ev;
		int          turn;
		longint      target;
		logic        want;
		ev   = '0;
		want = ~lvl;  // pin is active low
		rot_age = (rot_age >= AGE_MAX) ? AGE_MAX : rot_age + 1;
		btn_age = (btn_age >= AGE_MAX) ? AGE_MAX : btn_age + 1;
		if (!primed) begin
			// first sample only latches the pin levels
			primed      = 1;
			acc_phase   = ph;
			deb_pressed = want;
			return;
		end
		if (ph != acc_phase && rot_age >= rot_lock) begin
			turn = (gray_ord(ph) - gray_ord(acc_phase)) & 3;
			// a half turn (both channels flipped) is dropped but still accepted
			if (turn == 1 || turn == 3) begin
				target = longint'(knob_pos) + ((turn == 1) ? 1 : -1);
				if (target < longint'(min_pos))
					target = longint'(min_pos);
				else if (target > longint'(max_pos))
					target = longint'(max_pos);
				if (target != longint'(knob_pos)) begin
					ev.rot_ev = 1'b1;
					ev.dir    = (turn == 1) ? DIR_CW : DIR_CCW;
				end
				knob_pos = target[31:0];
			end
			acc_phase = ph;
			rot_age   = 0;
		end
		if (want != deb_pressed && btn_age >= btn_lock) begin
			deb_pressed = want;
			if (want)
				press_cnt = press_cnt + 16'd1;
			ev.btn_ev = 1'b1;
			btn_age   = 0;
		end
		if (ev.rot_ev || ev.btn_ev) begin
			ev.pos     = knob_pos;
			ev.pressed = deb_pressed;
			ev.presses = press_cnt;
			knob_events_due.push_back(ev);
		end
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_POS:  min_pos  = val;
			REG_MAX_POS:  max_pos  = val;
			REG_ROT_LOCK: rot_lock = val[15:0];
			REG_BTN_LOCK: btn_lock = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [31:0] lo, logic [31:0] hi, logic [15:0] rl, logic [15:0] bl);
		write_reg(REG_MIN_POS, lo);
		write_reg(REG_MAX_POS, hi);
		write_reg(REG_ROT_LOCK, {16'd0, rl});
		write_reg(REG_BTN_LOCK, {16'd0, bl});
	endtask

	// Queue one sample: t = +1 clockwise, -1 counterclockwise, 0 hold, 2 both channels flip.
	task automatic turn_knob(int t, logic lvl);
		cur_ph  = phase_at(gray_ord(cur_ph) + t + 4);
		cur_lvl = lvl;
		samples_to_send.push_back({5'd0, cur_lvl, cur_ph});
	endtask

	// Realistic knob handling: runs of detent steps, reversals, dwell, some contact bounce.
	task automatic knob_walk(int n, int unsigned max_hold);
		int unsigned r;
		int          t;
		logic        lvl;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				spin_ccw = ~spin_ccw;
			if (r < 50)
				t = spin_ccw ? -1 : 1;
			else if (r < 80)
				t = 0;
			else if (r < 88)
				t = spin_ccw ? 1 : -1;
			else if (r < 94)
				t = 2;
			else
				t = $urandom_range(0, 3);
			if (btn_left == 0) begin
				lvl = ~cur_lvl;
				// one in five button edges is a one-tick bounce
				btn_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_hold);
			end else begin
				lvl = cur_lvl;
				btn_left--;
			end
			turn_knob(t, lvl);
		end
	endtask

	task automatic pin_noise(int n);
		repeat (n) begin
			cur_ph  = 2'($urandom_range(0, 3));
			cur_lvl = 1'($urandom_range(0, 1));
			samples_to_send.push_back({5'd0, cur_lvl, cur_ph});
		end
	endtask

	// Wait until every sample is in and every predicted event is out, then let the pipe drain.
	task automatic settle();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || s_tvalid || knob_events_due.size() != 0);
		repeat (DRAIN_CY) @(negedge clk);
	endtask

	// Sender: offers queued samples; a request is predicted at the edge it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_sample(s_tdata[1:0], s_tdata[2]);
				samples_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (samples_to_send.size() != 0) begin
					s_tdata  <= samples_to_send.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= tight_send ? 0 : draw_gap(calm_tx);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if ($urandom_range(0, 199) == 0)
				calm_tx = ~calm_tx;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_left  <= 0;
			stall_left <= 0;
		end else begin
			if (hold_taken != hold_asks) begin
				hold_taken <= hold_asks;
				hold_left  <= HOLD_CY;
				m_tready   <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready   <= 1'b1;
				stall_left <= draw_gap(calm_rx);
			end
			if ($urandom_range(0, 199) == 0)
				calm_rx = ~calm_rx;
		end
	end

	// Monitor: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		knob_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			events_checked++;
			if (m_tuser[0])
				rot_events++;
			if (m_tuser[1])
				btn_events++;
			if (knob_events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result tuser=%0h tdata=%0h", $time, m_tuser, m_tdata);
			end else begin
				want = knob_events_due.pop_front();
				check_field("rotation_event", 32'(want.rot_ev), 32'(m_tuser[0]));
				check_field("step_direction", 32'(want.dir), 32'(m_tdata[1:0]));
				check_field("position_out", want.pos, m_tdata[33:2]);
				check_field("button_event", 32'(want.btn_ev), 32'(m_tuser[1]));
				check_field("press_state", 32'(want.pressed), 32'(m_tdata[34]));
				check_field("press_total", 32'(want.presses), 32'(m_tdata[50:35]));
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d events still due", knob_events_due.size());
		$display("Mismatches found");
		$finish;
	end

	// Sequencer: reset, then a series of register settings each with its own stimulus.
	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults. Priming sample, steps, press together with a step,
		// half turns, and a release held inside the button lockout.
		turn_knob(0, 1'b1);
		turn_knob(1, 1'b1);
		turn_knob(1, 1'b0);
		turn_knob(1, 1'b0);
		turn_knob(2, 1'b0);
		turn_knob(-1, 1'b1);
		turn_knob(2, 1'b1);
		turn_knob(0, 1'b1);
		knob_walk(150, 80);
		settle();

		// Bounds at the top of the range, no lockouts: jump to the bound,
		// then clamping with and without movement.
		set_all(32'h7FFF_FFFE, 32'h7FFF_FFFF, 16'd0, 16'd0);
		turn_knob(1, 1'b0);
		turn_knob(1, 1'b1);
		turn_knob(1, 1'b0);
		turn_knob(-1, 1'b1);
		turn_knob(-1, 1'b1);
		turn_knob(2, 1'b0);
		knob_walk(60, 4);
		settle();

		// Bounds at the bottom of the range: a step from far above lands on max.
		set_all(32'h8000_0000, 32'h8000_0001, 16'd0, 16'd0);
		turn_knob(-1, 1'b1);
		turn_knob(-1, 1'b1);
		turn_knob(-1, 1'b1);
		knob_walk(40, 4);
		settle();

		// Crossed bounds (min above max) with short lockouts.
		set_all(32'd5, -32'sd5, 16'd2, 16'd3);
		turn_knob(1, 1'b1);
		turn_knob(1, 1'b1);
		turn_knob(-1, 1'b1);
		turn_knob(-1, 1'b1);
		knob_walk(150, 8);
		settle();

		// Largest lockouts: changes stay pending almost the whole time.
		set_all(-32'sd1000, 32'sd1000, 16'hFFFF, 16'hFFFF);
		knob_walk(60, 20);
		settle();

		// Back-pressure: dense events while the receiver stops for a long stretch.
		set_all(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0);
		tight_send = 1;
		hold_asks++;
		pin_noise(250);
		settle();
		tight_send = 0;

		// Moderate lockouts and narrow bounds for the bulk of the random run.
		set_all(-32'sd40, 32'sd40, 16'd3, 16'd12);
		knob_walk(600, 30);
		settle();

		$display("Covered %0d pin samples over 7 register settings: %0d results checked,",
			samples_taken, events_checked);
		$display("%0d with a rotation event and %0d with a button event.", rot_events, btn_events);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== quadrature_knob_decoder.f =====
rtl/core/qkd_pkg.sv
rtl/core/qkd_rotation.sv
rtl/core/qkd_button.sv
rtl/core/quadrature_knob_decoder.sv
bench/tb_quadrature_knob_decoder.sv
